/* hdl/rcba_pkg.sv */
package rcba_pkg;

	localparam int COORD_W = 11;
	localparam int DIM_W = 12;
	localparam int PIX_W = 8;
	localparam int PIX_MAX = 255;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam int MAX_DIM_DEF = 2048;
	localparam int RATIO_FRAC_BITS_DEF = 16;

	localparam int EDGE_LEVEL = 250;
	localparam int GRAY_GAIN = 4;
	localparam int GRAY_OFFSET = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd2;

	localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH = 12'd200;
	localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 12'd200;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
		logic [PIX_W-1:0]   chan_blue;
		logic [PIX_W-1:0]   chan_green;
		logic [PIX_W-1:0]   chan_red;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_red;
	} result_t;

	typedef struct packed {
		logic [PIX_W-1:0] chan_blue;
		logic [PIX_W-1:0] chan_green;
		logic [PIX_W-1:0] chan_red;
	} rgb_t;

endpackage

/* hdl/radial_contrast_brightness_adjust.sv */
// Channel  Dir  Handshake                     Payload
// cfg      in   cfg_we                        cfg_index, cfg_data
// pixel    in   pixel_valid, pixel_ready      pixel (pixel_t)
// result   out  result_valid, result_ready    result (result_t)
//
// One request is taken per clock while pixel_ready is high. Each result passes through the
// distance stages, one square root step per stage, one divide step per stage and the blend
// stages. After reset and after every write of image_width or image_height, pixel_ready stays
// low while the half dimensions are latched, their squares summed and the center root found
// one bit per cycle. A result that is not taken fills a two-entry output buffer, and only then
// does the pipeline stop.
module radial_contrast_brightness_adjust
	import rcba_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  pixel_t                pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	localparam int CX_W = $clog2(MAX_DIM / 2 + 1);
	localparam int CEN_W = CX_W + 1;
	localparam int AD_W = (COORD_W > CX_W) ? COORD_W : CX_W;
	localparam int ROOT_W = AD_W + 1 + RATIO_FRAC_BITS;
	localparam int R_W = RATIO_FRAC_BITS + 2;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic              mode_q;
	logic              dims_wr;
	logic [CX_W-1:0]   cx;
	logic [CX_W-1:0]   cy;
	logic [CEN_W-1:0]  center;
	logic              busy;
	logic              adv;
	logic              accept;
	logic              root_v;
	logic [ROOT_W-1:0] root;
	rgb_t              root_rgb;
	logic              ratio_v;
	logic [R_W-1:0]    ratio;
	rgb_t              ratio_rgb;
	logic              pipe_v;
	result_t           pipe_res;
	logic              res_v_q;
	logic              skid_v_q;
	result_t           res_q;
	result_t           skid_q;
	logic              take;
	logic              incoming;

	assign dims_wr = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_IMAGE_WIDTH;
			height_q <= RESET_IMAGE_HEIGHT;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH: width_q <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_CHANNEL_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv = !skid_v_q;
	assign pixel_ready = adv && !busy;
	assign accept = pixel_valid && pixel_ready;

	rcba_center #(
		.MAX_DIM(MAX_DIM),
		.CX_W(CX_W)
	) u_center (
		.clk(clk),
		.arst_n(arst_n),
		.dims_wr(dims_wr),
		.image_width(width_q),
		.image_height(height_q),
		.cx(cx),
		.cy(cy),
		.center(center),
		.busy(busy)
	);

	rcba_dist #(
		.CX_W(CX_W),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(accept),
		.pixel(pixel),
		.cx(cx),
		.cy(cy),
		.out_valid(root_v),
		.out_root(root),
		.out_rgb(root_rgb)
	);

	rcba_ratio #(
		.CEN_W(CEN_W),
		.ROOT_W(ROOT_W),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(root_v),
		.in_root(root),
		.in_rgb(root_rgb),
		.center(center),
		.out_valid(ratio_v),
		.out_ratio(ratio),
		.out_rgb(ratio_rgb)
	);

	rcba_blend #(
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(ratio_v),
		.in_ratio(ratio),
		.in_rgb(ratio_rgb),
		.mode(mode_q),
		.out_valid(pipe_v),
		.out_res(pipe_res)
	);

	assign take = res_v_q && result_ready;
	assign incoming = pipe_v && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			priority if (take) begin
				if (skid_v_q) begin
					res_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					res_v_q <= incoming;
				end
			end else if (!res_v_q) begin
				res_v_q <= incoming;
			end else if (incoming) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (take && skid_v_q) begin
			res_q <= skid_q;
		end else if (take || !res_v_q) begin
			res_q <= pipe_res;
		end else if (incoming) begin
			skid_q <= pipe_res;
		end
	end

	assign result_valid = res_v_q;
	assign result = res_q;

endmodule

/* hdl/rcba_center.sv */
module rcba_center
	import rcba_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int CX_W = $clog2(MAX_DIM_DEF / 2 + 1),
	localparam int CEN_W = CX_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             dims_wr,
	input  logic [DIM_W-1:0] image_width,
	input  logic [DIM_W-1:0] image_height,
	output logic [CX_W-1:0]  cx,
	output logic [CX_W-1:0]  cy,
	output logic [CEN_W-1:0] center,
	output logic             busy
);

	localparam int REM_W = CEN_W + 2;
	localparam int NB_W = 2 * CEN_W;
	localparam int CNT_W = $clog2(CEN_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIMS = 2'd1;
	localparam logic [1:0] ST_SUM = 2'd2;
	localparam logic [1:0] ST_ROOT = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CX_W-1:0]   cx_q;
	logic [CX_W-1:0]   cy_q;
	logic [NB_W-1:0]   n_q;
	logic [REM_W-1:0]  rem_q;
	logic [CEN_W-1:0]  root_q;
	logic [2*CX_W-1:0] cx_sq;
	logic [2*CX_W-1:0] cy_sq;
	logic [NB_W-1:0]   sq_sum;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	function automatic logic [CX_W-1:0] half_dim(input logic [DIM_W-1:0] dim);
		if (32'(dim) > MAX_DIM) begin
			return CX_W'(MAX_DIM / 2);
		end
		return CX_W'(dim >> 1);
	endfunction

	assign cx_sq = cx_q * cx_q;
	assign cy_sq = cy_q * cy_q;
	assign sq_sum = NB_W'(cx_sq) + NB_W'(cy_sq);

	assign rem_sh = {rem_q[REM_W-3:0], n_q[NB_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign take = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIMS;
			cnt_q <= '0;
		end else if (dims_wr) begin
			state_q <= ST_DIMS;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= ST_IDLE;
				ST_DIMS: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					cnt_q <= CNT_W'(CEN_W - 1);
				end
				ST_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIMS) begin
			cx_q <= half_dim(image_width);
			cy_q <= half_dim(image_height);
		end
		if (state_q == ST_SUM) begin
			n_q <= sq_sum;
			rem_q <= '0;
			root_q <= '0;
		end
		if (state_q == ST_ROOT) begin
			n_q <= n_q << 2;
			rem_q <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[CEN_W-2:0], take};
		end
	end

	assign cx = cx_q;
	assign cy = cy_q;
	assign center = root_q;
	assign busy = state_q != ST_IDLE;

endmodule

/* hdl/rcba_dist.sv */
module rcba_dist
	import rcba_pkg::*;
#(
	parameter int CX_W = $clog2(MAX_DIM_DEF / 2 + 1),
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	localparam int AD_W = (COORD_W > CX_W) ? COORD_W : CX_W,
	localparam int ROOT_W = AD_W + 1 + RATIO_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  pixel_t            pixel,
	input  logic [CX_W-1:0]   cx,
	input  logic [CX_W-1:0]   cy,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output rgb_t              out_rgb
);

	localparam int NB_W = 2 * AD_W + 2;
	localparam int REM_W = ROOT_W + 2;

	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic [AD_W-1:0]   adr_s1;
	logic [AD_W-1:0]   adc_s1;
	logic [2*AD_W-1:0] sqr_s2;
	logic [2*AD_W-1:0] sqc_s2;
	logic [NB_W-1:0]   d2_s3;
	rgb_t              rgb_s1;
	rgb_t              rgb_s2;
	rgb_t              rgb_s3;
	logic [AD_W-1:0]   adr_d;
	logic [AD_W-1:0]   adc_d;

	logic              v_s [ROOT_W];
	logic [NB_W-1:0]   n_s [ROOT_W];
	logic [REM_W-1:0]  rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	rgb_t              rgb_s [ROOT_W];

	assign adr_d = (pixel.pixel_row >= cx) ? AD_W'(pixel.pixel_row - cx)
		: AD_W'(cx - pixel.pixel_row);
	assign adc_d = (pixel.pixel_col >= cy) ? AD_W'(pixel.pixel_col - cy)
		: AD_W'(cy - pixel.pixel_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adr_s1 <= adr_d;
			adc_s1 <= adc_d;
			rgb_s1 <= {pixel.chan_blue, pixel.chan_green, pixel.chan_red};
			sqr_s2 <= adr_s1 * adr_s1;
			sqc_s2 <= adc_s1 * adc_s1;
			rgb_s2 <= rgb_s1;
			d2_s3 <= NB_W'(sqr_s2) + NB_W'(sqc_s2);
			rgb_s3 <= rgb_s2;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic              v_in;
		logic [NB_W-1:0]   n_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		rgb_t              rgb_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in = v_s3;
			assign n_in = d2_s3;
			assign rem_in = '0;
			assign root_in = '0;
			assign rgb_in = rgb_s3;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign n_in = n_s[k-1];
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rgb_in = rgb_s[k-1];
		end

		assign rem_sh = {rem_in[REM_W-3:0], n_in[NB_W-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign take = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[k] <= n_in << 2;
				rem_s[k] <= take ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_in[ROOT_W-2:0], take};
				rgb_s[k] <= rgb_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_rgb = rgb_s[ROOT_W-1];

endmodule

/* hdl/rcba_ratio.sv */
module rcba_ratio
	import rcba_pkg::*;
#(
	parameter int CEN_W = $clog2(MAX_DIM_DEF / 2 + 1) + 1,
	parameter int ROOT_W = COORD_W + 1 + RATIO_FRAC_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	localparam int R_W = RATIO_FRAC_BITS + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] in_root,
	input  rgb_t              in_rgb,
	input  logic [CEN_W-1:0]  center,
	output logic              out_valid,
	output logic [R_W-1:0]    out_ratio,
	output rgb_t              out_rgb
);

	logic              v_s1;
	logic              sat_s1;
	logic              zero_s1;
	logic [CEN_W-1:0]  rem_s1;
	logic [R_W-1:0]    lo_s1;
	rgb_t              rgb_s1;
	logic [ROOT_W-1:0] hi_d;

	logic              v_s [R_W];
	logic              sat_s [R_W];
	logic              zero_s [R_W];
	logic [CEN_W-1:0]  rem_s [R_W];
	logic [R_W-1:0]    lo_s [R_W];
	rgb_t              rgb_s [R_W];

	assign hi_d = in_root >> R_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= in_root == '0;
			sat_s1 <= (in_root != '0) && (hi_d >= ROOT_W'(center));
			rem_s1 <= CEN_W'(hi_d);
			lo_s1 <= in_root[R_W-1:0];
			rgb_s1 <= in_rgb;
		end
	end

	for (genvar k = 0; k < R_W; k++) begin : g_step
		logic             v_in;
		logic             sat_in;
		logic             zero_in;
		logic [CEN_W-1:0] rem_in;
		logic [R_W-1:0]   lo_in;
		rgb_t             rgb_in;
		logic [CEN_W:0]   part;
		logic             take;

		if (k == 0) begin : g_first
			assign v_in = v_s1;
			assign sat_in = sat_s1;
			assign zero_in = zero_s1;
			assign rem_in = rem_s1;
			assign lo_in = lo_s1;
			assign rgb_in = rgb_s1;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign sat_in = sat_s[k-1];
			assign zero_in = zero_s[k-1];
			assign rem_in = rem_s[k-1];
			assign lo_in = lo_s[k-1];
			assign rgb_in = rgb_s[k-1];
		end

		assign part = {rem_in, lo_in[R_W-1]};
		assign take = part >= {1'b0, center};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sat_s[k] <= sat_in;
				zero_s[k] <= zero_in;
				rem_s[k] <= take ? CEN_W'(part - {1'b0, center}) : CEN_W'(part);
				lo_s[k] <= {lo_in[R_W-2:0], take};
				rgb_s[k] <= rgb_in;
			end
		end
	end

	assign out_valid = v_s[R_W-1];
	assign out_rgb = rgb_s[R_W-1];

	always_comb begin
		priority if (zero_s[R_W-1]) begin
			out_ratio = '0;
		end else if (sat_s[R_W-1]) begin
			out_ratio = '1;
		end else begin
			out_ratio = lo_s[R_W-1];
		end
	end

endmodule

/* hdl/rcba_blend.sv */
module rcba_blend
	import rcba_pkg::*;
#(
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	localparam int R_W = RATIO_FRAC_BITS + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [R_W-1:0] in_ratio,
	input  rgb_t           in_rgb,
	input  logic           mode,
	output logic           out_valid,
	output result_t        out_res
);

	localparam int PRD_W = R_W + PIX_W + 2;
	localparam int V_W = PRD_W + 1;
	localparam int G_W = PIX_W + 3;

	logic                    v_s1;
	logic                    v_s2;
	logic signed [PRD_W-1:0] prod_b_s1;
	logic signed [PRD_W-1:0] prod_g_s1;
	logic signed [PRD_W-1:0] prod_r_s1;
	rgb_t                    rgb_s1;
	result_t                 res_s2;
	logic [G_W-1:0]          gray_sum;
	logic [PIX_W-1:0]        gray;
	result_t                 res_d;

	function automatic logic signed [PRD_W-1:0] weight(input logic [R_W-1:0] r,
		input logic [PIX_W-1:0] p);
		logic signed [PIX_W:0] diff;
		diff = $signed((PIX_W + 1)'(EDGE_LEVEL)) - $signed({1'b0, p});
		return $signed({1'b0, r}) * diff;
	endfunction

	function automatic logic [PIX_W-1:0] finish(input logic [PIX_W-1:0] p,
		input logic signed [PRD_W-1:0] prod);
		logic signed [V_W-1:0] v;
		logic [V_W-1:0]        q;
		v = $signed({{(V_W - PIX_W - RATIO_FRAC_BITS){1'b0}}, p, {RATIO_FRAC_BITS{1'b0}}})
			+ prod;
		q = ($unsigned(v) + (V_W'(1) << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
		if (v[V_W-1] || v == '0) begin
			return '0;
		end
		return (q > V_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : q[PIX_W-1:0];
	endfunction

	assign gray_sum = G_W'(rgb_s1.chan_blue) * G_W'(GRAY_GAIN) + G_W'(GRAY_OFFSET);
	assign gray = (gray_sum > G_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : gray_sum[PIX_W-1:0];

	always_comb begin
		if (mode) begin
			res_d.out_blue = gray;
			res_d.out_green = '0;
			res_d.out_red = '0;
		end else begin
			res_d.out_blue = finish(rgb_s1.chan_blue, prod_b_s1);
			res_d.out_green = finish(rgb_s1.chan_green, prod_g_s1);
			res_d.out_red = finish(rgb_s1.chan_red, prod_r_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_b_s1 <= weight(in_ratio, in_rgb.chan_blue);
			prod_g_s1 <= weight(in_ratio, in_rgb.chan_green);
			prod_r_s1 <= weight(in_ratio, in_rgb.chan_red);
			rgb_s1 <= in_rgb;
			res_s2 <= res_d;
		end
	end

	assign out_valid = v_s2;
	assign out_res = res_s2;

endmodule

/* hdl/rcba_checker.sv */
module rcba_checker
	import rcba_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  pixel_valid,
	input logic                  pixel_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input result_t               result
);

	logic       mode_q;
	logic [7:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = pixel_valid && pixel_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pend_q <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_CHANNEL_MODE) begin
				mode_q <= cfg_data[0];
			end
			pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	a_busy_after_dims: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)
		|=> !pixel_ready)
		else $error("pixel accepted before the center was recomputed");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != '0)
		else $error("result shown without an outstanding request");

	a_gray_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mode_q |-> result.out_green == '0 && result.out_red == '0
		&& result.out_blue >= PIX_W'(GRAY_OFFSET))
		else $error("single-channel result has the wrong form");

endmodule

bind radial_contrast_brightness_adjust rcba_checker u_rcba_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data),
	.pixel_valid(pixel_valid),
	.pixel_ready(pixel_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

/* dv/rcba_scoreboard.sv */
module rcba_scoreboard
	import rcba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	input  logic                  pixel_ready,
	input  pixel_t                pixel,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = RATIO_FRAC_BITS_DEF;
	localparam longint unsigned RATIO_MAX = (64'd1 << (FRAC + 2)) - 64'd1;

	logic [DIM_W-1:0] image_width;
	logic [DIM_W-1:0] image_height;
	logic             gray_mode;
	result_t          expected_pixels[$];

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned rem;
		longint unsigned trial;
		root = 0;
		rem = 0;
		for (int i = 31; i >= 0; i--) begin
			rem = (rem << 2) | ((n >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned half_dim(input logic [DIM_W-1:0] dim);
		longint unsigned lim;
		lim = dim;
		if (lim > MAX_DIM_DEF) begin
			lim = MAX_DIM_DEF;
		end
		return lim / 2;
	endfunction

	function automatic logic [PIX_W-1:0] blend_toward_edge(input logic [PIX_W-1:0] p,
			input longint unsigned ratio);
		longint v;
		longint q;
		v = (longint'(p) <<< FRAC) + longint'(ratio) * (EDGE_LEVEL - longint'(p));
		if (v <= 0) begin
			return '0;
		end
		q = (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		return (q > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(q);
	endfunction

	function automatic result_t predict_adjusted(input pixel_t px);
		longint unsigned cx;
		longint unsigned cy;
		longint unsigned center;
		longint unsigned d2;
		longint unsigned ratio;
		longint unsigned gray;
		longint dr;
		longint dc;
		result_t res;
		if (gray_mode) begin
			gray = GRAY_GAIN * px.chan_blue + GRAY_OFFSET;
			res.out_blue = (gray > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(gray);
			res.out_green = '0;
			res.out_red = '0;
			return res;
		end
		cx = half_dim(image_width);
		cy = half_dim(image_height);
		center = int_sqrt(cx * cx + cy * cy);
		dr = longint'(px.pixel_row) - longint'(cx);
		dc = longint'(px.pixel_col) - longint'(cy);
		d2 = dr * dr + dc * dc;
		if (d2 == 0) begin
			ratio = 0;
		end else if (center == 0) begin
			ratio = RATIO_MAX;
		end else begin
			ratio = int_sqrt(d2 << (2 * FRAC)) / center;
			if (ratio > RATIO_MAX) begin
				ratio = RATIO_MAX;
			end
		end
		res.out_blue = blend_toward_edge(px.chan_blue, ratio);
		res.out_green = blend_toward_edge(px.chan_green, ratio);
		res.out_red = blend_toward_edge(px.chan_red, ratio);
		return res;
	endfunction

	task automatic check_channel(input string chan, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, chan, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			image_width = RESET_IMAGE_WIDTH;
			image_height = RESET_IMAGE_HEIGHT;
			gray_mode = 1'b0;
			expected_pixels.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: image_width = cfg_data[DIM_W-1:0];
					CFG_IMAGE_HEIGHT: image_height = cfg_data[DIM_W-1:0];
					CFG_CHANNEL_MODE: gray_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got %h", $time, result);
				end else begin
					want = expected_pixels.pop_front();
					check_channel("out_blue", want.out_blue, result.out_blue);
					check_channel("out_green", want.out_green, result.out_green);
					check_channel("out_red", want.out_red, result.out_red);
				end
			end
			if (pixel_valid && pixel_ready) begin
				expected_pixels.push_back(predict_adjusted(pixel));
			end
			outstanding = expected_pixels.size();
		end
	end

endmodule

/* dv/tb_radial_contrast_brightness_adjust.sv */
module tb_radial_contrast_brightness_adjust;
	timeunit 1ns;
	timeprecision 1ps;

	import rcba_pkg::*;

	localparam int SEGMENTS = 10;
	localparam int ITEMS_PER_SEG = 125;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL = 400;
	localparam int DRAIN_TAIL = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pixel_valid;
	logic                  pixel_ready;
	pixel_t                pixel;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;

	int mismatches;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_requests;
	int cycles;
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;

	radial_contrast_brightness_adjust dut (.*);

	rcba_scoreboard scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// A long stall is requested by bumping stall_requests; the count runs down here.
	initial begin
		int hold_left;
		int stalls_seen;
		hold_left = 0;
		stalls_seen = 0;
		result_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_requests != stalls_seen) begin
				stalls_seen = stall_requests;
				hold_left = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_pixel(input int row, input int col, input int blue, input int green,
			input int red);
		pixel_t px;
		px.pixel_row = row[COORD_W-1:0];
		px.pixel_col = col[COORD_W-1:0];
		px.chan_blue = blue[PIX_W-1:0];
		px.chan_green = green[PIX_W-1:0];
		px.chan_red = red[PIX_W-1:0];
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (!pixel_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input int mode);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= w[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_CHANNEL_MODE;
		cfg_data <= CFG_DATA_W'(mode);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_width = w[DIM_W-1:0];
		cur_height = h[DIM_W-1:0];
	endtask

	function automatic int random_dim();
		int extremes[7];
		extremes = '{0, 1, 2, 2047, 2048, 2049, 4095};
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 4095);
			1: return $urandom_range(1, 64);
			2: return $urandom_range(100, 800);
			default: return extremes[$urandom_range(0, 6)];
		endcase
	endfunction

	// Most pixels fall inside the image so that the blend weight spans its useful range.
	task automatic send_random_pixel();
		int row_top;
		int col_top;
		int chan[3];
		row_top = (cur_width > 2047) ? 2047 : cur_width;
		col_top = (cur_height > 2047) ? 2047 : cur_height;
		for (int c = 0; c < 3; c++) begin
			case ($urandom_range(0, 9))
				0: chan[c] = 0;
				1: chan[c] = 255;
				default: chan[c] = $urandom_range(0, 255);
			endcase
		end
		if ($urandom_range(0, 4) != 0) begin
			send_pixel($urandom_range(0, row_top), $urandom_range(0, col_top),
				chan[0], chan[1], chan[2]);
		end else begin
			send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
				chan[0], chan[1], chan[2]);
		end
	endtask

	initial begin
		int seg;
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pixel_valid <= 1'b0;
		pixel <= '0;
		cur_width = RESET_IMAGE_WIDTH;
		cur_height = RESET_IMAGE_HEIGHT;
		tx_idle_pct = 10;
		rx_idle_pct = 60;
		stall_requests = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pixel(100, 100, 0, 128, 255);
		send_pixel(100, 100, 255, 0, 250);
		send_pixel(0, 0, 0, 255, 17);
		send_pixel(2047, 2047, 255, 0, 128);
		send_pixel(2047, 0, 1, 254, 200);
		send_pixel(0, 2047, 85, 170, 5);

		configure(1, 0, 0);
		send_pixel(0, 0, 10, 20, 30);
		send_pixel(0, 1, 10, 20, 30);
		send_pixel(1024, 2047, 255, 255, 255);

		configure(4095, 2048, 0);
		send_pixel(1024, 1024, 7, 250, 251);
		send_pixel(0, 0, 0, 100, 255);
		send_pixel(2047, 2047, 255, 249, 0);

		configure(640, 480, 1);
		send_pixel(0, 0, 0, 255, 255);
		send_pixel(300, 200, 38, 1, 2);
		send_pixel(2047, 2047, 39, 0, 0);
		send_pixel(5, 9, 255, 255, 255);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 4) begin
				tx_idle_pct = 10;
				rx_idle_pct = 60;
			end else if (seg < 8) begin
				tx_idle_pct = 60;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (seg == 0) begin
				configure(1, 4095, 0);
			end else if (seg == SEGMENTS - 1) begin
				configure(2048, 1, 0);
			end else begin
				configure(random_dim(), random_dim(), (seg == 5) || ($urandom_range(0, 4) == 0));
			end
			for (k = 0; k < ITEMS_PER_SEG; k++) begin
				if (seg == 8 && k == 20) begin
					stall_requests++;
				end
				if (seg == 9 && k == 60) begin
					drain();
				end
				send_random_pixel();
			end
		end

		drain();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
